### src/bdlp_pkg.sv
package bdlp_pkg;

  // Physical button slots carried by one item
  localparam int unsigned SLOTS = 5;

  localparam int unsigned BUTTONS_DEF   = 5;
  localparam int unsigned AGE_WIDTH_DEF = 16;

  localparam int unsigned LP_WIDTH   = 16;
  localparam int unsigned DEB_WIDTH  = 8;
  localparam int unsigned IDX_WIDTH  = 8;
  localparam int unsigned DATA_WIDTH = 16;

  localparam logic [LP_WIDTH-1:0]  LONG_PRESS_RST = LP_WIDTH'(1000);
  localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RST   = DEB_WIDTH'(50);

  // Configuration register indexes
  localparam logic [IDX_WIDTH-1:0] REG_LONG_PRESS = IDX_WIDTH'(0);
  localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE   = IDX_WIDTH'(1);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_LONG    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_HELD     = 3'd2,
    EV_RELEASED = 3'd3,
    EV_LONG     = 3'd4
  } event_e;

  // What one lane reports for the current tick
  typedef struct packed {
    event_e evt;
    logic   stable;
    logic   notify;
  } lane_res_t;

endpackage

### src/bdlp_in_if.sv
interface bdlp_in_if;
  import bdlp_pkg::*;
  logic                valid;
  logic                ready;
  logic [SLOTS-1:0]    pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

### src/bdlp_out_if.sv
interface bdlp_out_if;
  import bdlp_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       event_b0;
  logic [2:0]       event_b1;
  logic [2:0]       event_b2;
  logic [2:0]       event_b3;
  logic [2:0]       event_b4;
  logic [SLOTS-1:0] stable_mask;
  logic [SLOTS-1:0] notify_mask;

  modport source (output valid, output event_b0, output event_b1, output event_b2,
                  output event_b3, output event_b4, output stable_mask,
                  output notify_mask, input ready);
  modport sink   (input valid, input event_b0, input event_b1, input event_b2,
                  input event_b3, input event_b4, input stable_mask,
                  input notify_mask, output ready);
endinterface

### src/bdlp_cfg_if.sv
interface bdlp_cfg_if;
  import bdlp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [IDX_WIDTH-1:0]  index;
  logic [DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/bdlp_lane.sv
module bdlp_lane
  import bdlp_pkg::*;
#(
  parameter int unsigned AgeWidth = AGE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 raw_i,        // 1 = pressed
  input  logic [LP_WIDTH-1:0]  long_press_i,
  input  logic [DEB_WIDTH-1:0] debounce_i,
  output lane_res_t            res_o
);

  localparam int unsigned CmpWidth = (AgeWidth > LP_WIDTH) ? AgeWidth : LP_WIDTH;

  logic                prior_q, prior_d;
  logic                stable_q, stable_d;
  mode_e               mode_q, mode_d;
  logic [AgeWidth-1:0] deb_age_q, deb_age_d;
  logic [AgeWidth-1:0] mode_age_q, mode_age_d;
  logic [AgeWidth-1:0] tis;
  logic                long_hit;
  logic                restart;
  event_e              evt;

  assign prior_d   = raw_i;
  assign deb_age_d = (raw_i != prior_q) ? '0 :
                     ((&deb_age_q) ? deb_age_q : deb_age_q + AgeWidth'(1));
  assign stable_d  = (CmpWidth'(deb_age_d) > CmpWidth'(debounce_i)) ? raw_i : stable_q;
  assign tis       = (&mode_age_q) ? mode_age_q : mode_age_q + AgeWidth'(1);
  assign long_hit  = CmpWidth'(tis) >= CmpWidth'(long_press_i);

  // next mode
  always_comb begin
    mode_d  = mode_q;
    restart = 1'b0;
    case (mode_q)
      MODE_IDLE: begin
        if (stable_d) begin
          mode_d  = MODE_PRESSED;
          restart = 1'b1;
        end
      end
      MODE_PRESSED: begin
        if (!stable_d) begin
          mode_d  = MODE_IDLE;
          restart = 1'b1;
        end else if (long_hit) begin
          mode_d  = MODE_LONG;
          restart = 1'b1;
        end
      end
      default: begin
        if (!stable_d) begin
          mode_d  = MODE_IDLE;
          restart = 1'b1;
        end
      end
    endcase
  end

  assign mode_age_d = restart ? '0 : tis;

  // event for this tick
  always_comb begin
    case (mode_q)
      MODE_IDLE:    evt = stable_d ? EV_PRESSED : EV_NONE;
      MODE_PRESSED: evt = !stable_d ? EV_RELEASED : (long_hit ? EV_LONG : EV_HELD);
      default:      evt = !stable_d ? EV_RELEASED : EV_HELD;
    endcase
  end

  assign res_o.evt    = evt;
  assign res_o.stable = stable_d;
  assign res_o.notify = (evt == EV_PRESSED) || (evt == EV_RELEASED) || (evt == EV_LONG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q    <= 1'b0;
      stable_q   <= 1'b0;
      mode_q     <= MODE_IDLE;
      deb_age_q  <= '0;
      mode_age_q <= '0;
    end else if (accept_i) begin
      prior_q    <= prior_d;
      stable_q   <= stable_d;
      mode_q     <= mode_d;
      deb_age_q  <= deb_age_d;
      mode_age_q <= mode_age_d;
    end
  end

endmodule

### src/bdlp_merge.sv
module bdlp_merge
  import bdlp_pkg::*;
#(
  parameter int unsigned Buttons = BUTTONS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  lane_res_t [Buttons-1:0] lanes_i,
  output logic                    free_o,
  bdlp_out_if.source              out_o
);

  lane_res_t [SLOTS-1:0] slot;
  logic                  vld_q, vld_d;
  logic [2:0]            evt_q [SLOTS];
  logic [SLOTS-1:0]      stable_q, notify_q;

  // absent slots read as no event
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    if (s < Buttons) begin : g_used
      assign slot[s] = lanes_i[s];
    end else begin : g_unused
      assign slot[s] = '{evt: EV_NONE, stable: 1'b0, notify: 1'b0};
    end
  end

  assign free_o = !vld_q || out_o.ready;
  assign vld_d  = accept_i || (vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int s = 0; s < SLOTS; s++) begin
        evt_q[s]    <= slot[s].evt;
        stable_q[s] <= slot[s].stable;
        notify_q[s] <= slot[s].notify;
      end
    end
  end

  assign out_o.valid       = vld_q;
  assign out_o.event_b0    = evt_q[0];
  assign out_o.event_b1    = evt_q[1];
  assign out_o.event_b2    = evt_q[2];
  assign out_o.event_b3    = evt_q[3];
  assign out_o.event_b4    = evt_q[4];
  assign out_o.stable_mask = stable_q;
  assign out_o.notify_mask = notify_q;

endmodule

### src/button_debounce_long_press.sv
// Results of a tick item appear on the output in the cycle after it is accepted.
// Throughput: one tick item per cycle when not stalled; every lane updates
//   and the output register takes a new item whenever it is empty or drained.
// Reset (rst_ni low, asynchronous): all buttons idle and not pressed, ages
//   zero, long-press time = 1000, debounce time = 50, no result pending.
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int unsigned BUTTONS   = BUTTONS_DEF,
  parameter int unsigned AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdlp_cfg_if.sink   cfg_i,
  bdlp_in_if.sink    in_i,
  bdlp_out_if.source out_o
);

  // Configuration registers, written whenever offered; unknown indexes drop.
  logic [LP_WIDTH-1:0]  long_press_q;
  logic [DEB_WIDTH-1:0] debounce_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RST;
      debounce_q   <= DEBOUNCE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_LONG_PRESS: long_press_q <= cfg_i.data[LP_WIDTH-1:0];
        REG_DEBOUNCE:   debounce_q   <= cfg_i.data[DEB_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: a tick is taken whenever the output stage can hold it.
  logic                    out_free;
  logic                    accept;
  logic [SLOTS-1:0]        pressed;
  lane_res_t [BUTTONS-1:0] lane_res;

  assign in_i.ready = out_free;
  assign accept     = in_i.valid && out_free;
  assign pressed    = ~in_i.pin_levels;   // pins are active low

  // One lane per button: debounce counter, stable level, press/long machine.
  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    bdlp_lane #(
      .AgeWidth (AGE_WIDTH)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .accept_i     (accept),
      .raw_i        (pressed[b]),
      .long_press_i (long_press_q),
      .debounce_i   (debounce_q),
      .res_o        (lane_res[b])
    );
  end

  // Merge lane results into one registered result item.
  bdlp_merge #(
    .Buttons (BUTTONS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .lanes_i  (lane_res),
    .free_o   (out_free),
    .out_o    (out_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bdlp_pkg::*;

  // Ticks can be taken back to back; these bound the waits around phase changes
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 5000;
  localparam int SEG_ITEMS     = 240;
  localparam int HOLD_TICKS    = 270;
  localparam int LET_GO_TICKS  = 270;

  // Indexes with no register behind them; writes there must change nothing
  localparam logic [IDX_WIDTH-1:0] REG_SPARE_LO = IDX_WIDTH'(REG_DEBOUNCE + 1);
  localparam logic [IDX_WIDTH-1:0] REG_SPARE_HI = '1;

  // Register settings of the random segments: debounce window, long-press time
  localparam int SEG_DEBOUNCE [6] = '{2, 255, 0, 5, 1, 9};
  localparam int SEG_LONG     [6] = '{10, 3, 0, 30, 1, 47};

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_WRITE
  } row_kind_e;

  // One line of the directed table; evts packs the five events, button 0 lowest
  typedef struct packed {
    row_kind_e             kind;
    logic [IDX_WIDTH-1:0]  idx;
    logic [DATA_WIDTH-1:0] data;
    logic [SLOTS-1:0]      pins;
    logic                  typed;
    logic [3*SLOTS-1:0]    evts;
    logic [SLOTS-1:0]      stable;
    logic [SLOTS-1:0]      notify;
  } dir_row_t;

  // What one tick should report
  typedef struct {
    event_e           evt [SLOTS];
    logic [SLOTS-1:0] stable;
    logic [SLOTS-1:0] notify;
  } tick_res_t;

  // Directed part. Index field is unused on tick rows.
  localparam dir_row_t DIR_ROWS [32] = '{
    // right after reset, 50-tick debounce: nothing can settle yet
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b1, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b1, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h0A, 1'b1, 15'h0, 5'h00, 5'h00},
    // writes to unmapped indexes are dropped
    '{ROW_WRITE, REG_SPARE_LO,   16'hFFFF, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_WRITE, REG_SPARE_HI,   16'h1234, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    // debounce 0 (upper data bits must be masked off), zero long-press time
    '{ROW_WRITE, REG_DEBOUNCE,   16'hAB00, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_WRITE, REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    // press all: pressed, then long press on the very next tick, then held
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    // release all: one tick of held, then released, then quiet; then buttons 1 and 3 press
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h15, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h15, 1'b0, 15'h0, 5'h00, 5'h00},
    // widest debounce window and longest long-press time
    '{ROW_WRITE, REG_DEBOUNCE,   16'h00FF, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_WRITE, REG_LONG_PRESS, 16'hFFFF, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    // short windows: buttons 0, 2, 4 press, held, long press after two ticks, release
    '{ROW_WRITE, REG_DEBOUNCE,   16'h0001, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_WRITE, REG_LONG_PRESS, 16'h0002, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h00, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00},
    '{ROW_TICK,  REG_LONG_PRESS, 16'h0000, 5'h1F, 1'b0, 15'h0, 5'h00, 5'h00}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bdlp_cfg_if cfg_if ();
  bdlp_in_if  in_if ();
  bdlp_out_if out_if ();

  button_debounce_long_press uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Button model: own copy of registers and per-button state
  // ---------------------------------------------------------------------------
  logic [LP_WIDTH-1:0]      cfg_long_press;
  logic [DEB_WIDTH-1:0]     cfg_debounce;
  logic [SLOTS-1:0]         seen_raw;     // last raw pressed level
  logic [SLOTS-1:0]         settled;      // debounced pressed level
  mode_e                    btn_mode   [SLOTS];
  logic [AGE_WIDTH_DEF-1:0] settle_age [SLOTS];
  logic [AGE_WIDTH_DEF-1:0] mode_age   [SLOTS];

  tick_res_t due_reports [$];   // reports owed by the block, oldest first
  int        mismatch_count = 0;
  int        stall_cycles   = 0;
  int        src_idle_pct   = 0;
  int        snk_idle_pct   = 0;

  // Random press generator: per-button level, remaining hold and chatter ticks
  logic [SLOTS-1:0] gen_level;
  int               gen_hold    [SLOTS];
  int               gen_chatter [SLOTS];

  function automatic logic [AGE_WIDTH_DEF-1:0] age_step(input logic [AGE_WIDTH_DEF-1:0] a);
    return (a == '1) ? a : a + 1'b1;   // ages stick at all-ones
  endfunction

  // Advance every button by one tick and return what the block must report
  function automatic tick_res_t advance_buttons(input logic [SLOTS-1:0] pins);
    tick_res_t                r;
    logic [SLOTS-1:0]         pressed;
    logic [AGE_WIDTH_DEF-1:0] tis;
    pressed  = ~pins;
    r.notify = '0;
    for (int i = 0; i < SLOTS; i++) begin
      r.evt[i] = EV_NONE;
      if (i < BUTTONS_DEF) begin
        // any raw edge restarts the debounce age
        if (pressed[i] != seen_raw[i]) begin
          settle_age[i] = '0;
        end else begin
          settle_age[i] = age_step(settle_age[i]);
        end
        seen_raw[i] = pressed[i];
        if (settle_age[i] > cfg_debounce) begin
          settled[i] = pressed[i];
        end

        tis = age_step(mode_age[i]);
        case (btn_mode[i])
          MODE_IDLE: begin
            if (settled[i]) begin
              btn_mode[i] = MODE_PRESSED;
              tis         = '0;
              r.evt[i]    = EV_PRESSED;
            end
          end
          MODE_PRESSED: begin
            if (!settled[i]) begin
              btn_mode[i] = MODE_IDLE;
              tis         = '0;
              r.evt[i]    = EV_RELEASED;
            end else if (tis >= cfg_long_press) begin
              btn_mode[i] = MODE_LONG;
              tis         = '0;
              r.evt[i]    = EV_LONG;
            end else begin
              r.evt[i] = EV_HELD;
            end
          end
          default: begin
            if (!settled[i]) begin
              btn_mode[i] = MODE_IDLE;
              tis         = '0;
              r.evt[i]    = EV_RELEASED;
            end else begin
              r.evt[i] = EV_HELD;
            end
          end
        endcase
        mode_age[i] = tis;
        r.notify[i] = (r.evt[i] != EV_NONE) && (r.evt[i] != EV_HELD);
      end
    end
    r.stable = settled;
    return r;
  endfunction

  // Next pin vector: mostly clean press/release waveforms with contact chatter
  // after each edge; some holds shorter than the debounce window, some pure noise.
  function automatic logic [SLOTS-1:0] next_pins();
    logic [SLOTS-1:0] p;
    int               span;
    if ($urandom_range(99) < 4) begin
      return SLOTS'($urandom_range(31));
    end
    span = (cfg_long_press > 60) ? 60 : int'(cfg_long_press);
    for (int i = 0; i < SLOTS; i++) begin
      if (gen_hold[i] <= 0) begin
        gen_level[i] = ~gen_level[i];
        if ($urandom_range(99) < 20) begin
          gen_hold[i] = $urandom_range(int'(cfg_debounce) + 1, 1);   // glitch
        end else begin
          gen_hold[i] = $urandom_range(int'(cfg_debounce) + span + 6,
                                       int'(cfg_debounce) + 2);
        end
        gen_chatter[i] = $urandom_range(3, 0);
      end
      gen_hold[i]--;
      if (gen_chatter[i] > 0) begin
        p[i] = 1'($urandom_range(1));
        gen_chatter[i]--;
      end else begin
        p[i] = gen_level[i];
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge; handshakes are sampled on
  // the rising edge, before the block's registers move.
  // ---------------------------------------------------------------------------

  // Offer one tick item; the report is predicted at the edge it is taken.
  // use_typed selects a hand-written expectation over the model's.
  task automatic send_tick(input logic [SLOTS-1:0] pins, input bit use_typed,
                           input tick_res_t typed);
    tick_res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.pin_levels <= pins;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = advance_buttons(pins);
    if (use_typed) begin
      due_reports.push_back(typed);
    end else begin
      due_reports.push_back(predicted);
    end
  endtask

  // Stop sending and wait until every owed report has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [DATA_WIDTH-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_LONG_PRESS) begin
      cfg_long_press = val[LP_WIDTH-1:0];
    end else if (idx == REG_DEBOUNCE) begin
      cfg_debounce = val[DEB_WIDTH-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Receiver back-pressure, redrawn every cycle
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Report checker
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_reports
    tick_res_t  want;
    logic [2:0] got [SLOTS];
    if (rst_ni && out_if.valid && out_if.ready) begin
      got[0] = out_if.event_b0;
      got[1] = out_if.event_b1;
      got[2] = out_if.event_b2;
      got[3] = out_if.event_b3;
      got[4] = out_if.event_b4;
      if (due_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: report with no tick pending, expected none, actual stable %0h notify %0h",
                 $time, out_if.stable_mask, out_if.notify_mask);
      end else begin
        want = due_reports.pop_front();
        for (int i = 0; i < SLOTS; i++) begin
          if (got[i] !== want.evt[i]) begin
            flag_mismatch($sformatf("event_b%0d", i), int'(want.evt[i]), int'(got[i]));
          end
        end
        if (out_if.stable_mask !== want.stable) begin
          flag_mismatch("stable_mask", int'(want.stable), int'(out_if.stable_mask));
        end
        if (out_if.notify_mask !== want.notify) begin
          flag_mismatch("notify_mask", int'(want.notify), int'(out_if.notify_mask));
        end
      end
    end
  end

  // Watchdog: cycles in a row in which no channel moved an item
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t  row;
    tick_res_t typed;
    tick_res_t no_typed;

    // all inputs known from time zero; buttons released
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.pin_levels = '1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_LONG_PRESS;
    cfg_if.data      = '0;

    // model state after reset
    cfg_long_press = LONG_PRESS_RST;
    cfg_debounce   = DEBOUNCE_RST;
    seen_raw       = '0;
    settled        = '0;
    for (int i = 0; i < SLOTS; i++) begin
      btn_mode[i]    = MODE_IDLE;
      settle_age[i]  = '0;
      mode_age[i]    = '0;
      no_typed.evt[i] = EV_NONE;
    end
    no_typed.stable = '0;
    no_typed.notify = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, under the first idling mix
    src_idle_pct = 19;
    snk_idle_pct = 68;
    for (int k = 0; k < $size(DIR_ROWS); k++) begin
      row = DIR_ROWS[k];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.data);
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          typed.evt[i] = event_e'(row.evts[3*i +: 3]);
        end
        typed.stable = row.stable;
        typed.notify = row.notify;
        send_tick(row.pins, row.typed, typed);
      end
    end

    // Random segments: three idling mixes, two register settings each
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 68 : 0;
      snk_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 19 : 0;
      for (int s = 0; s < 2; s++) begin
        drain_results();
        // junk in the upper data bits of the debounce write must be ignored
        write_reg(REG_DEBOUNCE, {8'($urandom_range(255)), 8'(SEG_DEBOUNCE[2*ph + s])});
        write_reg(REG_LONG_PRESS, 16'(SEG_LONG[2*ph + s]));
        if ($urandom_range(1) == 1) begin
          write_reg(IDX_WIDTH'($urandom_range(int'(REG_SPARE_HI), int'(REG_SPARE_LO))),
                    16'($urandom_range(16'hFFFF)));
        end
        gen_level = '1;
        for (int i = 0; i < SLOTS; i++) begin
          gen_hold[i]    = $urandom_range(5, 0);
          gen_chatter[i] = 0;
        end
        for (int n = 0; n < SEG_ITEMS; n++) begin
          // now and then hold off until the block has caught up completely
          if ($urandom_range(299) == 0) begin
            drain_results();
          end
          send_tick(next_pins(), 1'b0, no_typed);
        end
      end
    end

    // Longest windows: buttons 0..3 held past the widest debounce window, so
    // they settle, report pressed and then held; button 4 stays idle.
    drain_results();
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    for (int n = 0; n < HOLD_TICKS; n++) begin
      send_tick(5'h10, 1'b0, no_typed);
    end
    for (int n = 0; n < LET_GO_TICKS; n++) begin
      send_tick(5'h1F, 1'b0, no_typed);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
